// File: src/sitd_pkg.sv
// Package for the signed integer to decimal ASCII converter.
// Holds field widths, character codes, micro-op and condition codes and the
// control store; no dependencies.
`timescale 1ns / 1ps

package sitd_pkg;

  // Fixed widths of the request and result fields.
  localparam int VALUE_W = 64;
  localparam int CHAR_W  = 6;

  // Binary bits folded into the BCD register per double-dabble step.
  localparam int BITS_PER_STEP = 4;

  // Character codes.
  localparam logic [CHAR_W-1:0] CH_MINUS = 6'd45;
  localparam logic [CHAR_W-1:0] CH_ZERO  = 6'd48;

  // Micro-program counter width.
  localparam int PC_W = 3;

  typedef logic [PC_W-1:0] pc_t;
  typedef logic [2:0]      op_t;
  typedef logic [2:0]      cond_t;

  // Datapath operations.
  localparam op_t OP_NOP    = 3'd0;
  localparam op_t OP_LOAD   = 3'd1;
  localparam op_t OP_DABBLE = 3'd2;
  localparam op_t OP_SKIP   = 3'd3;
  localparam op_t OP_SIGN   = 3'd4;
  localparam op_t OP_DIGIT  = 3'd5;

  // Branch conditions.
  localparam cond_t C_NEVER     = 3'd0;
  localparam cond_t C_ALWAYS    = 3'd1;
  localparam cond_t C_NO_REQ    = 3'd2;
  localparam cond_t C_CNT_NZ    = 3'd3;
  localparam cond_t C_LEAD_ZERO = 3'd4;
  localparam cond_t C_NOT_LAST  = 3'd5;

  // Program step addresses.
  localparam pc_t PC_LOAD   = 3'd0;
  localparam pc_t PC_DABBLE = 3'd1;
  localparam pc_t PC_SKIP   = 3'd2;
  localparam pc_t PC_SIGN   = 3'd3;
  localparam pc_t PC_DIGIT  = 3'd4;
  localparam pc_t PC_END    = 3'd5;

  // One control word: operation, branch condition and branch target.
  typedef struct packed {
    op_t   op;
    cond_t cond;
    pc_t   target;
  } ctrl_t;

  // Status returned by the datapath to the sequencer.
  typedef struct packed {
    logic no_req;
    logic cnt_nz;
    logic lead_zero;
    logic last;
    logic stall;
  } status_t;

  // Control store. A step branches to its target when its condition holds,
  // and otherwise falls through to the next step.
  function automatic ctrl_t ucode(input pc_t pc);
    ctrl_t cw;
    unique case (pc)
      PC_LOAD:   cw = '{op: OP_LOAD,   cond: C_NO_REQ,    target: PC_LOAD};
      PC_DABBLE: cw = '{op: OP_DABBLE, cond: C_CNT_NZ,    target: PC_DABBLE};
      PC_SKIP:   cw = '{op: OP_SKIP,   cond: C_LEAD_ZERO, target: PC_SKIP};
      PC_SIGN:   cw = '{op: OP_SIGN,   cond: C_NEVER,     target: PC_LOAD};
      PC_DIGIT:  cw = '{op: OP_DIGIT,  cond: C_NOT_LAST,  target: PC_DIGIT};
      PC_END:    cw = '{op: OP_NOP,    cond: C_ALWAYS,    target: PC_LOAD};
      default:   cw = '{op: OP_NOP,    cond: C_ALWAYS,    target: PC_LOAD};
    endcase
    return cw;
  endfunction

endpackage

// File: src/sitd_if.sv
// Valid/ready channel interfaces for the converter's request and result sides.
// Depends on sitd_pkg for the field widths.
`timescale 1ns / 1ps

interface sitd_value_if;
  logic                               valid;
  logic                               ready;
  logic signed [sitd_pkg::VALUE_W-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

interface sitd_char_if;
  logic                        valid;
  logic                        ready;
  logic [sitd_pkg::CHAR_W-1:0] char_code;
  logic                        is_last;

  modport source (output valid, output char_code, output is_last, input ready);
  modport sink   (input valid, input char_code, input is_last, output ready);
endinterface

// File: src/sitd_sequencer.sv
// Micro-program sequencer: step counter, control store lookup and branching.
// Depends on sitd_pkg for the control word, status and the control store.
`timescale 1ns / 1ps

module sitd_sequencer (
  input  logic              clk,
  input  logic              rst,
  input  sitd_pkg::status_t status,
  output sitd_pkg::ctrl_t   ctrl
);

  sitd_pkg::pc_t pc;
  sitd_pkg::pc_t pc_next;
  logic          taken;

  assign ctrl = sitd_pkg::ucode(pc);

  always_comb begin
    unique case (ctrl.cond)
      sitd_pkg::C_NEVER:     taken = 1'b0;
      sitd_pkg::C_ALWAYS:    taken = 1'b1;
      sitd_pkg::C_NO_REQ:    taken = status.no_req;
      sitd_pkg::C_CNT_NZ:    taken = status.cnt_nz;
      sitd_pkg::C_LEAD_ZERO: taken = status.lead_zero;
      sitd_pkg::C_NOT_LAST:  taken = !status.last;
      default:               taken = 1'b1;
    endcase
  end

  // A step whose result cannot be handed on yet is repeated.
  always_comb begin
    if (status.stall) begin
      pc_next = pc;
    end else if (taken) begin
      pc_next = ctrl.target;
    end else begin
      pc_next = pc + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= sitd_pkg::PC_LOAD;
    end else begin
      pc <= pc_next;
    end
  end

endmodule

// File: src/sitd_datapath.sv
// Datapath: magnitude and BCD registers, step and digit counters, output stage.
// Depends on sitd_pkg and the channel interfaces in sitd_if.sv.
`timescale 1ns / 1ps

module sitd_datapath #(
  parameter int VALUE_BITS = 64
) (
  input  logic              clk,
  input  logic              rst,
  input  sitd_pkg::ctrl_t   ctrl,
  output sitd_pkg::status_t status,
  sitd_value_if.sink        value_ch,
  sitd_char_if.source       char_ch
);

  localparam int BPS    = sitd_pkg::BITS_PER_STEP;
  localparam int STEPS  = (VALUE_BITS + BPS - 1) / BPS;
  localparam int MAG_W  = STEPS * BPS;
  localparam int DIGITS = (VALUE_BITS * 77) / 256 + 1;
  localparam int BCD_W  = DIGITS * 4;
  localparam int CNT_W  = (STEPS > 2) ? $clog2(STEPS) : 1;
  localparam int LEFT_W = $clog2(DIGITS);

  logic [MAG_W-1:0]  mag;
  logic [BCD_W-1:0]  bcd;
  logic [CNT_W-1:0]  cnt;
  logic [LEFT_W-1:0] left;
  logic              neg;

  logic                        out_valid;
  logic [sitd_pkg::CHAR_W-1:0] out_char;
  logic                        out_last;

  logic [VALUE_BITS-1:0] raw;
  logic [VALUE_BITS-1:0] abs_val;
  logic [MAG_W-1:0]      mag_dab;
  logic [BCD_W-1:0]      bcd_dab;
  logic [3:0]            top_digit;
  logic                  can_emit;
  logic                  accept;

  assign raw       = value_ch.value[VALUE_BITS-1:0];
  assign abs_val   = raw[VALUE_BITS-1] ? (~raw + 1'b1) : raw;
  assign top_digit = bcd[BCD_W-1 -: 4];
  assign can_emit  = !out_valid || char_ch.ready;

  // No request is taken while reset is held.
  assign value_ch.ready = (ctrl.op == sitd_pkg::OP_LOAD) && !rst;
  assign accept         = value_ch.valid && value_ch.ready;

  assign status.no_req    = !value_ch.valid;
  assign status.cnt_nz    = (cnt != '0);
  assign status.lead_zero = (top_digit == 4'd0) && (left != '0);
  assign status.last      = (left == '0);
  assign status.stall     = !can_emit &&
                            ((ctrl.op == sitd_pkg::OP_DIGIT) ||
                             ((ctrl.op == sitd_pkg::OP_SIGN) && neg));

  assign char_ch.valid     = out_valid;
  assign char_ch.char_code = out_char;
  assign char_ch.is_last   = out_last;

  // Several shift-and-add-3 steps: every BCD digit of 5 or more gets 3 added
  // before the next magnitude bit is shifted in.
  always_comb begin
    logic [BCD_W-1:0] b;
    logic [MAG_W-1:0] m;
    b = bcd;
    m = mag;
    for (int s = 0; s < BPS; s++) begin
      for (int d = 0; d < DIGITS; d++) begin
        if (b[d*4 +: 4] >= 4'd5) begin
          b[d*4 +: 4] = b[d*4 +: 4] + 4'd3;
        end
      end
      b = {b[BCD_W-2:0], m[MAG_W-1]};
      m = {m[MAG_W-2:0], 1'b0};
    end
    bcd_dab = b;
    mag_dab = m;
  end

  always_ff @(posedge clk) begin
    unique case (ctrl.op)
      sitd_pkg::OP_LOAD: begin
        if (accept) begin
          mag  <= MAG_W'(abs_val);
          neg  <= raw[VALUE_BITS-1];
          bcd  <= '0;
          cnt  <= CNT_W'(STEPS - 1);
          left <= LEFT_W'(DIGITS - 1);
        end
      end
      sitd_pkg::OP_DABBLE: begin
        mag <= mag_dab;
        bcd <= bcd_dab;
        cnt <= cnt - 1'b1;
      end
      sitd_pkg::OP_SKIP: begin
        if (status.lead_zero) begin
          bcd  <= {bcd[BCD_W-5:0], 4'd0};
          left <= left - 1'b1;
        end
      end
      sitd_pkg::OP_DIGIT: begin
        if (can_emit && (left != '0)) begin
          bcd  <= {bcd[BCD_W-5:0], 4'd0};
          left <= left - 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  // Output register: holds one character until the receiver takes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      if ((ctrl.op == sitd_pkg::OP_DIGIT) && can_emit) begin
        out_valid <= 1'b1;
      end else if ((ctrl.op == sitd_pkg::OP_SIGN) && neg && can_emit) begin
        out_valid <= 1'b1;
      end else if (char_ch.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if ((ctrl.op == sitd_pkg::OP_DIGIT) && can_emit) begin
      out_char <= sitd_pkg::CH_ZERO + sitd_pkg::CHAR_W'(top_digit);
      out_last <= (left == '0);
    end else if ((ctrl.op == sitd_pkg::OP_SIGN) && neg && can_emit) begin
      out_char <= sitd_pkg::CH_MINUS;
      out_last <= 1'b0;
    end
  end

endmodule

// File: src/signed_int_to_decimal_ascii_top.sv
// Top level of the signed integer to decimal ASCII converter.
// Depends on sitd_pkg, sitd_if.sv, sitd_sequencer and sitd_datapath.
//
// Each request on value_ch carries one two's complement integer whose low
// VALUE_BITS bits count, bit VALUE_BITS-1 being the sign. Its decimal text
// leaves on char_ch, one ASCII character per transfer, most significant first:
// a minus sign for negative values, then the digits with no leading zeros
// (zero gives '0', the most negative value its full magnitude). is_last marks
// the final character of each number.
//
// One request is handled at a time; the BCD register holds
// D = floor(VALUE_BITS*77/256) + 1 digits. A conversion takes one double-dabble
// step per four bits, one step per leading zero dropped or digit sent, the step
// that finds the first significant digit, the sign, closing and load steps; a
// minus sign is registered before the first digit. A stalled receiver holds
// the character in the output register and freezes the sequencer in the sign
// or digit step; reset returns to the load step, empties the output and holds
// ready low.
`timescale 1ns / 1ps

module signed_int_to_decimal_ascii_top #(
  parameter int VALUE_BITS = 64
) (
  input  logic        clk,
  input  logic        rst,
  sitd_value_if.sink  value_ch,
  sitd_char_if.source char_ch
);

  // Control word from the sequencer to the datapath, and status back.
  sitd_pkg::ctrl_t   ctrl;
  sitd_pkg::status_t status;

  // The sequencer steps through the control store; its branches follow the
  // datapath's status (request waiting, steps left, leading zero, last digit)
  // and it holds a sign or digit step while the output register cannot take a character.
  sitd_sequencer u_seq (
    .clk    (clk),
    .rst    (rst),
    .status (status),
    .ctrl   (ctrl)
  );

  // The datapath takes the magnitude, converts it to BCD four bits per step,
  // drops leading zero digits and streams the characters out.
  sitd_datapath #(
    .VALUE_BITS (VALUE_BITS)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .ctrl     (ctrl),
    .status   (status),
    .value_ch (value_ch),
    .char_ch  (char_ch)
  );

endmodule
